/* hdl/pit_pkg.sv */
// Shared constants for the point-in-triangle test unit.
// Used by pit_mul and point_in_triangle_test_unit; no dependencies.
`timescale 1ns / 1ps
package pit_pkg;

  // Partial-product chunk width of the pipelined multiplier
  localparam int unsigned MUL_CW = 32;
  // Register stages through one pipelined multiplier
  localparam int unsigned MUL_LAT = 4;
  // Total register stages from input transfer to output register
  localparam int unsigned PIPE_DEPTH = 3 * MUL_LAT + 4;

  // Configuration register map
  localparam int unsigned TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
  localparam logic REG_IDX_TOL = 1'b0;

endpackage

/* hdl/point_in_triangle_test_unit.sv */
// Point-in-triangle test: plane distance check plus three same-side tests.
// Accepts one item per cycle while the output register is free or taken.
// Throughput is set by a fully pipelined datapath with a global stall.
// Reset clears the valid bits and loads the tolerance register tol_q with 66.
// Depends on pit_pkg and pit_mul.
`timescale 1ns / 1ps
module point_in_triangle_test_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_z_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_z_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_z_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic                         off_plane_o
);
  import pit_pkg::*;

  localparam int unsigned DW   = COORD_BITS + 1;      // edge vectors
  localparam int unsigned XW   = 2 * COORD_BITS + 3;  // cross products
  localparam int unsigned DTW  = DW + XW + 2;         // plane distance dot
  localparam int unsigned SW   = 2 * XW + 2;          // cross dot products
  localparam int unsigned TTW  = 2 * TOL_W + 1;       // tol^2, signed
  localparam int unsigned CMPW = (2 * DTW > TTW + SW) ? 2 * DTW : TTW + SW;
  localparam int unsigned NX   = 5;
  localparam int unsigned NY   = 4;

  // cross operand pairs: u x v, f x g, f x h, v x w, u x w
  localparam int XA [NX] = '{0, 3, 3, 1, 0};
  localparam int XB [NX] = '{1, 4, 5, 2, 2};
  // dot operand pairs: N.N, (fxg).(fxh), (vxw).N, (uxw).N
  localparam int YA [NY] = '{0, 1, 3, 4};
  localparam int YB [NY] = '{0, 2, 0, 0};

  logic en;
  logic [PIPE_DEPTH-1:0] vld_q;

  // config register
  logic [TOL_W-1:0]  tol_q;
  logic [TTW-2:0]    tt_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_IDX_TOL);
  assign prdata = (paddr[2] == REG_IDX_TOL) ? 32'(tol_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_wr) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // tolerance squared; the user must keep it static while items are in flight (not enforced here)
  always_ff @(posedge clk_i) begin
    tt_q <= (TTW-1)'(tol_q) * (TTW-1)'(tol_q);
  end

  // global stall: pipeline moves when the output register is free or taken
  assign en          = ~vld_q[PIPE_DEPTH-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // stage 1: edge vectors u=B-A v=C-A w=P-A f=C-B g=P-B h=A-B
  logic signed [COORD_BITS-1:0] pt [3];
  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];
  logic signed [DW-1:0] diff_d [6][3];
  logic signed [DW-1:0] diff_q [6][3];

  assign pt = '{point_x_i, point_y_i, point_z_i};
  assign va = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign vb = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign vc = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_d[0][c] = DW'(vb[c]) - DW'(va[c]);
      diff_d[1][c] = DW'(vc[c]) - DW'(va[c]);
      diff_d[2][c] = DW'(pt[c]) - DW'(va[c]);
      diff_d[3][c] = DW'(vc[c]) - DW'(vb[c]);
      diff_d[4][c] = DW'(pt[c]) - DW'(vb[c]);
      diff_d[5][c] = DW'(va[c]) - DW'(vb[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= diff_d;
    end
  end

  // stages 2-5: cross product terms
  logic signed [2*DW-1:0] pa [NX][3][2];

  for (genvar k = 0; k < NX; k++) begin : g_xk
    for (genvar c = 0; c < 3; c++) begin : g_xc
      pit_mul #(.AW(DW), .BW(DW)) u_mul_p (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (diff_q[XA[k]][(c+1)%3]),
        .b_i   (diff_q[XB[k]][(c+2)%3]),
        .p_o   (pa[k][c][0])
      );
      pit_mul #(.AW(DW), .BW(DW)) u_mul_n (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (diff_q[XA[k]][(c+2)%3]),
        .b_i   (diff_q[XB[k]][(c+1)%3]),
        .p_o   (pa[k][c][1])
      );
    end
  end

  // w travels alongside to meet the normal
  logic signed [DW-1:0] w_pipe [MUL_LAT+1][3];

  // stage 6: cross products; index 0 is the normal N
  logic signed [XW-1:0] x_q [NX][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_pipe[0] <= diff_q[2];
      for (int s = 1; s <= MUL_LAT; s++) begin
        w_pipe[s] <= w_pipe[s-1];
      end
      for (int k = 0; k < NX; k++) begin
        for (int c = 0; c < 3; c++) begin
          x_q[k][c] <= XW'(pa[k][c][0]) - XW'(pa[k][c][1]);
        end
      end
    end
  end

  // stages 7-10: dot product terms
  logic signed [2*XW-1:0]  pb [NY][3];
  logic signed [DW+XW-1:0] pd [3];

  for (genvar j = 0; j < NY; j++) begin : g_yj
    for (genvar c = 0; c < 3; c++) begin : g_yc
      pit_mul #(.AW(XW), .BW(XW)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (x_q[YA[j]][c]),
        .b_i   (x_q[YB[j]][c]),
        .p_o   (pb[j][c])
      );
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_dc
    pit_mul #(.AW(DW), .BW(XW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (w_pipe[MUL_LAT][c]),
      .b_i   (x_q[0][c]),
      .p_o   (pd[c])
    );
  end

  // stage 11: dot sums; dot_q[0] is |N|^2
  logic signed [SW-1:0]  dot_q [NY];
  logic signed [DTW-1:0] d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NY; j++) begin
        dot_q[j] <= SW'(pb[j][0]) + SW'(pb[j][1]) + SW'(pb[j][2]);
      end
      d_q <= DTW'(pd[0]) + DTW'(pd[1]) + DTW'(pd[2]);
    end
  end

  // stages 12-15: squared distance and scaled tolerance
  logic signed [2*DTW-1:0]  lhs_p;
  logic signed [TTW+SW-1:0] rhs_p;
  logic signed [TTW-1:0]    tt_s;

  assign tt_s = $signed({1'b0, tt_q});

  pit_mul #(.AW(DTW), .BW(DTW)) u_mul_lhs (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (d_q),
    .b_i   (d_q),
    .p_o   (lhs_p)
  );

  pit_mul #(.AW(TTW), .BW(SW)) u_mul_rhs (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (tt_s),
    .b_i   (dot_q[0]),
    .p_o   (rhs_p)
  );

  // same-side flags; the middle edge has its second cross negated, so <= 0
  logic [2:0] ss_pipe [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_pipe[0] <= {~dot_q[3][SW-1],
                     dot_q[2][SW-1] | (dot_q[2] == '0),
                     ~dot_q[1][SW-1]};
      for (int s = 1; s < MUL_LAT; s++) begin
        ss_pipe[s] <= ss_pipe[s-1];
      end
    end
  end

  // stage 16: compare and output register
  logic off_d;
  logic inside_d;
  logic off_q;
  logic inside_q;

  assign off_d    = CMPW'(lhs_p) > CMPW'(rhs_p);
  assign inside_d = (&ss_pipe[MUL_LAT-1]) & ~off_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      off_q    <= off_d;
      inside_q <= inside_d;
    end
  end

  assign off_plane_o  = off_q;
  assign inside_res_o = inside_q;

endmodule

/* hdl/pit_mul.sv */
// Pipelined signed multiplier built from 32x32 unsigned partial products.
// Registers magnitudes, partial products, row sums and result, advancing on enable; depends on pit_pkg.
`timescale 1ns / 1ps
module pit_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import pit_pkg::*;

  localparam int unsigned NA = (AW + MUL_CW - 1) / MUL_CW;
  localparam int unsigned NB = (BW + MUL_CW - 1) / MUL_CW;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned RW = (NB + 1) * MUL_CW;

  logic [AW-1:0]          mag_a;
  logic [BW-1:0]          mag_b;
  logic [NA*MUL_CW-1:0]   ma_q;
  logic [NB*MUL_CW-1:0]   mb_q;
  logic [MUL_LAT-2:0]     sg_q;
  logic [2*MUL_CW-1:0]    pp_d [NA][NB];
  logic [2*MUL_CW-1:0]    pp_q [NA][NB];
  logic [RW-1:0]          row_d [NA];
  logic [RW-1:0]          row_q [NA];
  logic [PW-1:0]          acc;
  logic [PW-1:0]          p_d;
  logic [PW-1:0]          p_q;

  // magnitudes; the most negative value maps to its unsigned magnitude
  assign mag_a = a_i[AW-1] ? AW'(~a_i + 1'b1) : AW'(a_i);
  assign mag_b = b_i[BW-1] ? BW'(~b_i + 1'b1) : BW'(b_i);

  // partial products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = (2*MUL_CW)'(ma_q[i*MUL_CW +: MUL_CW]) *
                     (2*MUL_CW)'(mb_q[j*MUL_CW +: MUL_CW]);
      end
    end
  end

  // row sums
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * MUL_CW));
      end
    end
  end

  // final sum and sign, modulo 2^PW (true magnitude always fits)
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (PW'(row_q[i]) << (i * MUL_CW));
    end
    p_d = sg_q[MUL_LAT-2] ? PW'(~acc + 1'b1) : acc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= (NA*MUL_CW)'(mag_a);
      mb_q  <= (NB*MUL_CW)'(mag_b);
      sg_q  <= {sg_q[MUL_LAT-3:0], a_i[AW-1] ^ b_i[BW-1]};
      pp_q  <= pp_d;
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  assign p_o = $signed(p_q);

endmodule

/* tb/point_in_triangle_test_unit_test.sv */
// Testbench for point_in_triangle_test_unit: random and directed point/triangle
// pairs checked against an exact-integer predictor. Depends on pit_pkg and the RTL.
`timescale 1ns / 1ps
module point_in_triangle_test_unit_test;
  import pit_pkg::*;

  localparam int CB = 32;
  localparam int WW = 240;  // wide enough for every exact product here

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_query_t;
  typedef struct packed {
    logic in_tri;
    logic off;
  } verdict_t;
  typedef logic signed [WW-1:0] wide_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic in_ready_o_q = 1'b0;  // input transfer seen at the last rising edge
  tri_query_t cur = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic inside_res_o, off_plane_o;

  logic [TOL_W-1:0] tolerance = TOL_RESET;
  tri_query_t query_q[$];
  verdict_t verdict_q[$];
  int n_mismatch = 0, n_checked = 0, n_inside = 0, n_off = 0;
  bit quiet = 1'b0;   // no idling during this stretch
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  point_in_triangle_test_unit u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .point_x_i(cur.px), .point_y_i(cur.py), .point_z_i(cur.pz),
    .vertex_a_x_i(cur.ax), .vertex_a_y_i(cur.ay), .vertex_a_z_i(cur.az),
    .vertex_b_x_i(cur.bx), .vertex_b_y_i(cur.by), .vertex_b_z_i(cur.bz),
    .vertex_c_x_i(cur.cx), .vertex_c_y_i(cur.cy), .vertex_c_z_i(cur.cz),
    .out_valid_o, .out_ready_i, .inside_res_o, .off_plane_o
  );

  // Same-side test: dot((b-a)x(p-a), (b-a)x(q-a)) >= 0
  function automatic bit same_side(wide_t p[3], wide_t q[3], wide_t a[3], wide_t b[3]);
    wide_t e[3], u[3], v[3], c1[3], c2[3];
    for (int i = 0; i < 3; i++) begin
      e[i] = b[i] - a[i];
      u[i] = p[i] - a[i];
      v[i] = q[i] - a[i];
    end
    c1[0] = e[1]*u[2] - e[2]*u[1]; c1[1] = e[2]*u[0] - e[0]*u[2];
    c1[2] = e[0]*u[1] - e[1]*u[0];
    c2[0] = e[1]*v[2] - e[2]*v[1]; c2[1] = e[2]*v[0] - e[0]*v[2];
    c2[2] = e[0]*v[1] - e[1]*v[0];
    return (c1[0]*c2[0] + c1[1]*c2[1] + c1[2]*c2[2]) >= 0;
  endfunction

  // Plane-distance check in squared form, then the same-side test against each edge
  function automatic verdict_t classify(tri_query_t t, logic [TOL_W-1:0] tol);
    wide_t p[3], a[3], b[3], c[3], e1[3], e2[3], n[3], d, nn, tw;
    verdict_t r;
    p = '{wide_t'(t.px), wide_t'(t.py), wide_t'(t.pz)};
    a = '{wide_t'(t.ax), wide_t'(t.ay), wide_t'(t.az)};
    b = '{wide_t'(t.bx), wide_t'(t.by), wide_t'(t.bz)};
    c = '{wide_t'(t.cx), wide_t'(t.cy), wide_t'(t.cz)};
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    n[0] = e1[1]*e2[2] - e1[2]*e2[1]; n[1] = e1[2]*e2[0] - e1[0]*e2[2];
    n[2] = e1[0]*e2[1] - e1[1]*e2[0];
    d = (p[0]-a[0])*n[0] + (p[1]-a[1])*n[1] + (p[2]-a[2])*n[2];
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    tw = wide_t'({1'b0, tol});
    r.off = (d*d > tw*tw*nn);
    r.in_tri = !r.off && same_side(p, a, b, c) && same_side(p, b, a, c)
               && same_side(p, c, a, b);
    return r;
  endfunction

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'h000F_FFFF)) - coord_t'(32'h0008_0000);
      default: return coord_t'($urandom_range(0, 63)) - 32;
    endcase
  endfunction

  // Random triangle; the point is random or a mix of vertices on, near or pushed outside the triangle
  function automatic tri_query_t rnd_query();
    tri_query_t t;
    int mode, kind, w1, w2, w3;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    t.ax = rnd_coord(mode); t.ay = rnd_coord(mode); t.az = rnd_coord(mode);
    t.bx = rnd_coord(mode); t.by = rnd_coord(mode); t.bz = rnd_coord(mode);
    t.cx = rnd_coord(mode); t.cy = rnd_coord(mode); t.cz = rnd_coord(mode);
    kind = $urandom_range(0, 9);
    if (kind < 3 || mode == 0) begin
      t.px = rnd_coord(mode); t.py = rnd_coord(mode); t.pz = rnd_coord(mode);
    end else begin
      w1 = $urandom_range(0, 8); w2 = $urandom_range(0, 8 - w1); w3 = 8 - w1 - w2;
      if (kind == 9) w3 = w3 + 3;  // push outside
      t.px = coord_t'((64'(signed'(t.ax))*w1 + 64'(signed'(t.bx))*w2
                       + 64'(signed'(t.cx))*w3) >>> 3);
      t.py = coord_t'((64'(signed'(t.ay))*w1 + 64'(signed'(t.by))*w2
                       + 64'(signed'(t.cy))*w3) >>> 3);
      t.pz = coord_t'((64'(signed'(t.az))*w1 + 64'(signed'(t.bz))*w2
                       + 64'(signed'(t.cz))*w3) >>> 3);
      if (kind == 8) t.pz = t.pz + coord_t'($urandom_range(0, 2000)) - 1000;
    end
    return t;
  endfunction

  // Driver: present queued items with random idle cycles and random output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o_q) begin
        if (query_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
          cur <= query_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= quiet || $urandom_range(0, 99) >= 8;
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    verdict_t got, want;
    in_ready_o_q <= in_ready_o && in_valid_i;
    if (rst_ni && in_valid_i && in_ready_o) verdict_q = {verdict_q, classify(cur, tolerance)};
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{in_tri: inside_res_o, off: off_plane_o};
      n_checked++;
      if (verdict_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result inside=%0b off=%0b", got.in_tri,
                                       got.off);
      end else begin
        want = verdict_q.pop_front();
        n_inside += want.in_tri;
        n_off += want.off;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: expected inside=%0b off=%0b, got inside=%0b off=%0b",
                     n_checked, want.in_tri, want.off, got.in_tri, got.off);
        end
      end
    end
  end

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_IDX_TOL, 2'b00}; pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tolerance = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (query_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    repeat (count) query_q = {query_q, rnd_query()};
    drain();
  endtask

  initial begin
    tri_query_t t;
    logic [TOL_W-1:0] tol_set[5];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: extremes, degenerate triangle, on-plane and off-plane points
    t = '0; query_q = {query_q, t};                                // all zero
    t = '{px: 1, py: 1, pz: 0, ax: 0, ay: 0, az: 0, bx: 65536, by: 0, bz: 0,
          cx: 0, cy: 65536, cz: 0, default: 0};
    query_q = {query_q, t};                                        // in the triangle
    t.pz = 67; query_q = {query_q, t};                             // just off
    t.pz = 66; query_q = {query_q, t};                             // on tolerance
    t.px = -5; t.pz = 0; query_q = {query_q, t};                   // outside edge
    t.px = 0; t.py = 0; query_q = {query_q, t};                    // at vertex
    t = '{default: 32'sh7FFF_FFFF}; query_q = {query_q, t};
    t = '{default: 32'sh8000_0000}; query_q = {query_q, t};
    t = '{px: 32'sh8000_0000, py: 32'sh7FFF_FFFF, pz: 32'sh8000_0000,
          ax: 32'sh7FFF_FFFF, ay: 32'sh8000_0000, az: 32'sh8000_0000,
          bx: 32'sh8000_0000, by: 32'sh7FFF_FFFF, bz: 32'sh7FFF_FFFF,
          cx: 32'sh7FFF_FFFF, cy: 32'sh7FFF_FFFF, cz: 32'sh8000_0000};
    query_q = {query_q, t};
    t = '{px: -1, py: -1, pz: -1, ax: 1, ay: 1, az: 1, bx: 2, by: 2, bz: 2,
          cx: 3, cy: 3, cz: 3};                                    // collinear
    query_q = {query_q, t};
    t.px = 1; t.py = 2; t.pz = 3; query_q = {query_q, t};
    repeat (10) query_q = {query_q, rnd_query()};
    drain();

    // Zero, max and a few mid tolerances, with random traffic under each
    tol_set = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'($urandom), TOL_RESET};
    foreach (tol_set[i]) begin
      write_tolerance(tol_set[i]);
      t = '{px: 3, py: 3, pz: 1, ax: 0, ay: 0, az: 0, bx: 100, by: 0, bz: 0,
            cx: 0, cy: 100, cz: 0};
      query_q = {query_q, t};
      if (i == 2) begin
        quiet = 1'b1;
        run_random(150);
        quiet = 1'b0;
      end
      run_random(230);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("checked %0d results (%0d inside, %0d off plane) over 5 tolerance settings",
             n_checked, n_inside, n_off);
    if (n_mismatch == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, verdict_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
